/* src/xt3_pkg.sv */
// Shared types, constants and round functions for the XTEA-3 block cipher.
package xt3_pkg;

    localparam int          XT3_ROUNDS   = 32;
    localparam int          XT3_KEY_WRDS = 8;
    localparam logic [31:0] XT3_DELTA    = 32'h9E37_79B9;

    // operation codes carried in tuser
    localparam logic XT3_KIND_ENC = 1'b0;
    localparam logic XT3_KIND_DEC = 1'b1;

    typedef logic [XT3_KEY_WRDS-1:0][31:0] xt3_key_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] w3;
        logic [31:0] w2;
        logic [31:0] w1;
        logic [31:0] w0;
    } xt3_blk_t;

    function automatic logic [31:0] xt3_rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} << n;
        return tmp[63:32];
    endfunction

    // v drives, w is the side word, s the running sum, sel picks the key pair
    function automatic logic [31:0] xt3_mix(input logic [31:0] v, input logic [31:0] w,
                                            input logic [31:0] s, input logic [1:0] sel,
                                            input xt3_key_t key);
        logic [31:0] left;
        logic [31:0] right;
        left  = (v << 4) + xt3_rotl(key[{1'b1, sel}], v[4:0]);
        right = (v >> 5) + xt3_rotl(key[{1'b0, sel}], v[31:27]);
        return left ^ (w + s) ^ right;
    endfunction

endpackage

/* src/xt3_whiten_cell.sv */
// Pipeline cell for input or output key whitening.
module xt3_whiten_cell import xt3_pkg::*; #(
    parameter bit IS_OUTPUT = 1'b0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  xt3_key_t key,
    input  logic     in_valid,
    output logic     in_ready,
    input  xt3_blk_t in_blk,
    output logic     out_valid,
    input  logic     out_ready,
    output xt3_blk_t out_blk
);

    logic     valid_reg;
    logic     valid_next;
    xt3_blk_t blk_reg;
    xt3_blk_t blk_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        blk_next = in_blk;
        // encrypt: add low keys going in, XOR high keys coming out; decrypt mirrors
        if ((in_blk.kind == XT3_KIND_ENC) == IS_OUTPUT) begin
            blk_next.w0 = in_blk.w0 ^ key[4];
            blk_next.w1 = in_blk.w1 ^ key[5];
            blk_next.w2 = in_blk.w2 ^ key[6];
            blk_next.w3 = in_blk.w3 ^ key[7];
        end else if (IS_OUTPUT) begin
            blk_next.w0 = in_blk.w0 - key[0];
            blk_next.w1 = in_blk.w1 - key[1];
            blk_next.w2 = in_blk.w2 - key[2];
            blk_next.w3 = in_blk.w3 - key[3];
        end else begin
            blk_next.w0 = in_blk.w0 + key[0];
            blk_next.w1 = in_blk.w1 + key[1];
            blk_next.w2 = in_blk.w2 + key[2];
            blk_next.w3 = in_blk.w3 + key[3];
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            blk_reg <= blk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule

/* src/xt3_round_cell.sv */
// Pipeline cell for one cipher round, encrypt or decrypt per request.
module xt3_round_cell import xt3_pkg::*; #(
    parameter int ROUNDS    = XT3_ROUNDS,
    parameter int ROUND_IDX = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  xt3_key_t key,
    input  logic     in_valid,
    output logic     in_ready,
    input  xt3_blk_t in_blk,
    output logic     out_valid,
    input  logic     out_ready,
    output xt3_blk_t out_blk
);

    localparam logic [63:0] ENC_P0 = 64'(ROUND_IDX) * 64'(XT3_DELTA);
    localparam logic [63:0] ENC_P1 = 64'(ROUND_IDX + 1) * 64'(XT3_DELTA);
    localparam logic [63:0] DEC_P0 = 64'(ROUNDS - ROUND_IDX - 1) * 64'(XT3_DELTA);
    localparam logic [63:0] DEC_P1 = 64'(ROUNDS - ROUND_IDX) * 64'(XT3_DELTA);
    localparam logic [31:0] ENC_S0 = ENC_P0[31:0];
    localparam logic [31:0] ENC_S1 = ENC_P1[31:0];
    localparam logic [31:0] DEC_S0 = DEC_P0[31:0];
    localparam logic [31:0] DEC_S1 = DEC_P1[31:0];

    logic        valid_reg;
    logic        valid_next;
    xt3_blk_t    blk_reg;
    xt3_blk_t    blk_next;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] mix_a;
    logic [31:0] mix_c;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        s0 = (in_blk.kind == XT3_KIND_DEC) ? DEC_S0 : ENC_S0;
        s1 = (in_blk.kind == XT3_KIND_DEC) ? DEC_S1 : ENC_S1;
        // decrypt rotates the words back before undoing the round
        if (in_blk.kind == XT3_KIND_DEC) begin
            a = in_blk.w3;
            b = in_blk.w0;
            c = in_blk.w1;
            d = in_blk.w2;
        end else begin
            a = in_blk.w0;
            b = in_blk.w1;
            c = in_blk.w2;
            d = in_blk.w3;
        end
        mix_a = xt3_mix(b, d, s0, s0[1:0], key);
        mix_c = xt3_mix(d, b, s1, s1[12:11], key);
        blk_next.kind = in_blk.kind;
        if (in_blk.kind == XT3_KIND_DEC) begin
            blk_next.w0 = a - mix_a;
            blk_next.w1 = b;
            blk_next.w2 = c - mix_c;
            blk_next.w3 = d;
        end else begin
            blk_next.w0 = b;
            blk_next.w1 = c + mix_c;
            blk_next.w2 = d;
            blk_next.w3 = a + mix_a;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            blk_reg <= blk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule

/* src/xtea3_block_cipher.sv */
// The chain holds ROUNDS + 2 register stages: input whitening, one cell per round, output whitening.
// Throughput: one block per cycle while the output is not stalled; every round is its own cell in the chain.
// Each cell holds while its successor stalls, so bubbles fill and new requests enter.
// Reset (synchronous, aresetn low) empties the chain and clears the key words to zero.
// Config port: APB, key word i at byte address 4*i, pready always high.
module xtea3_block_cipher import xt3_pkg::*; #(
    parameter int ROUNDS = XT3_ROUNDS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_word0, block_word1, block_word2, block_word3
    input  logic [0:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_word0, out_word1, out_word2, out_word3
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int STAGES = ROUNDS + 2;

    xt3_key_t key_reg;
    xt3_key_t key_next;
    logic     stg_valid [STAGES];
    logic     stg_ready [STAGES];
    xt3_blk_t stg_blk   [STAGES];
    xt3_blk_t in_blk;

    assign pready = 1'b1;
    assign prdata = key_reg[paddr[4:2]];

    always_comb begin
        key_next = key_reg;
        if (psel && penable && pwrite && pready) begin
            key_next[paddr[4:2]] = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    assign in_blk.kind = s_tuser[0];
    assign in_blk.w0   = s_tdata[31:0];
    assign in_blk.w1   = s_tdata[63:32];
    assign in_blk.w2   = s_tdata[95:64];
    assign in_blk.w3   = s_tdata[127:96];

    xt3_whiten_cell #(
        .IS_OUTPUT(1'b0)
    ) u_whiten_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key      (key_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_blk   (in_blk),
        .out_valid(stg_valid[0]),
        .out_ready(stg_ready[1]),
        .out_blk  (stg_blk[0])
    );

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        xt3_round_cell #(
            .ROUNDS   (ROUNDS),
            .ROUND_IDX(r)
        ) u_round (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .key      (key_reg),
            .in_valid (stg_valid[r]),
            .in_ready (stg_ready[r+1]),
            .in_blk   (stg_blk[r]),
            .out_valid(stg_valid[r+1]),
            .out_ready(stg_ready[r+2]),
            .out_blk  (stg_blk[r+1])
        );
    end

    xt3_whiten_cell #(
        .IS_OUTPUT(1'b1)
    ) u_whiten_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key      (key_reg),
        .in_valid (stg_valid[STAGES-2]),
        .in_ready (stg_ready[STAGES-1]),
        .in_blk   (stg_blk[STAGES-2]),
        .out_valid(stg_valid[STAGES-1]),
        .out_ready(m_tready),
        .out_blk  (stg_blk[STAGES-1])
    );

    // stage 0 has no upstream cell; its ready is the port itself
    assign stg_ready[0] = s_tready;

    assign m_tvalid = stg_valid[STAGES-1];
    assign m_tdata  = {stg_blk[STAGES-1].w3, stg_blk[STAGES-1].w2,
                       stg_blk[STAGES-1].w1, stg_blk[STAGES-1].w0};

`ifndef NO_ASSERTIONS
    // a free output lets the whole chain advance
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a result appears only from a block held in the last round cell
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(stg_valid[STAGES-2]))
        else $error("result without a block in the last round");

    a_stall_holds_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && stg_valid[STAGES-2]) |-> !stg_ready[STAGES-2])
        else $error("last round cell accepts while full chain stalls");
`endif

endmodule

/* test/xtea3_block_cipher_tb.sv */
// Self-checking testbench for the XTEA-3 128-bit block cipher stream core.
`timescale 1ns / 1ps

module xtea3_block_cipher_tb;
    import xt3_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = XT3_ROUNDS + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RAND_PHASES   = 5;
    localparam int RAND_PER_PASS = 80;
    localparam int N_CORNERS     = 12;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;   // block_word0, block_word1, block_word2, block_word3
    logic [0:0]   s_tuser  = '0;   // kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;         // out_word0, out_word1, out_word2, out_word3
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [4:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    logic [31:0]  key_shadow [XT3_KEY_WRDS];
    logic [127:0] pending_blocks [$];
    int           errors    = 0;
    int           cycles    = 0;
    logic         calm      = 1'b0;
    int           hold_req  = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    // kind in bit 128, then word3 .. word0
    logic [128:0] corner_blocks [N_CORNERS] = '{
        {XT3_KIND_ENC, 128'h00000000_00000000_00000000_00000000},
        {XT3_KIND_DEC, 128'h00000000_00000000_00000000_00000000},
        {XT3_KIND_ENC, 128'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF},
        {XT3_KIND_DEC, 128'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF},
        {XT3_KIND_ENC, 128'h80000000_80000000_80000000_80000000},
        {XT3_KIND_DEC, 128'h00000001_00000001_00000001_00000001},
        {XT3_KIND_ENC, 128'hAAAAAAAA_55555555_AAAAAAAA_55555555},
        {XT3_KIND_DEC, 128'h55555555_AAAAAAAA_55555555_AAAAAAAA},
        // both rotation counts zero on the first round: encrypt with all-zero keys, decrypt with all-one keys
        {XT3_KIND_ENC, 128'h07FFFFE0_07FFFFE0_07FFFFE0_07FFFFE0},
        {XT3_KIND_DEC, 128'hF800001F_F800001F_F800001F_F800001F},
        {XT3_KIND_ENC, 128'h00000000_FFFFFFFF_00000000_FFFFFFFF},
        {XT3_KIND_DEC, 128'h01234567_89ABCDEF_FEDCBA98_76543210}
    };

    xtea3_block_cipher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
        int unsigned amt;
        amt = n % 32;
        if (amt == 0) return x;
        return (x << amt) | (x >> (32 - amt));
    endfunction

    function automatic logic [31:0] round_mix(input logic [31:0] v, input logic [31:0] w,
                                              input logic [31:0] s, input logic [1:0] pair);
        logic [31:0] lhs;
        logic [31:0] rhs;
        lhs = (v << 4) + rotate_left(key_shadow[4 + pair], v[4:0]);
        rhs = (v >> 5) + rotate_left(key_shadow[pair], v[31:27]);
        return lhs ^ (w + s) ^ rhs;
    endfunction

    function automatic logic [127:0] xtea3_transform(input logic kind, input logic [127:0] blk);
        logic [31:0] a, b, c, d, t, sum;
        if (kind == XT3_KIND_ENC) begin
            sum = '0;
            a = blk[31:0]   + key_shadow[0];
            b = blk[63:32]  + key_shadow[1];
            c = blk[95:64]  + key_shadow[2];
            d = blk[127:96] + key_shadow[3];
            for (int r = 0; r < XT3_ROUNDS; r++) begin
                a = a + round_mix(b, d, sum, sum[1:0]);
                sum = sum + XT3_DELTA;
                c = c + round_mix(d, b, sum, sum[12:11]);
                t = a; a = b; b = c; c = d; d = t;
            end
            a = a ^ key_shadow[4];
            b = b ^ key_shadow[5];
            c = c ^ key_shadow[6];
            d = d ^ key_shadow[7];
        end else begin
            sum = XT3_DELTA * 32'(XT3_ROUNDS);
            a = blk[31:0]   ^ key_shadow[4];
            b = blk[63:32]  ^ key_shadow[5];
            c = blk[95:64]  ^ key_shadow[6];
            d = blk[127:96] ^ key_shadow[7];
            for (int r = 0; r < XT3_ROUNDS; r++) begin
                t = d; d = c; c = b; b = a; a = t;
                c = c - round_mix(d, b, sum, sum[12:11]);
                sum = sum - XT3_DELTA;
                a = a - round_mix(b, d, sum, sum[1:0]);
            end
            a = a - key_shadow[0];
            b = b - key_shadow[1];
            c = c - key_shadow[2];
            d = d - key_shadow[3];
        end
        return {d, c, b, a};
    endfunction

    // mostly random, with enough edge values that every bit sees both levels
    function automatic logic [31:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    task automatic reg_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        key_shadow[idx] = value;
    endtask

    task automatic reg_read_check(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 5'(4 * idx);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== key_shadow[idx]) begin
            $error("key_word%0d: expected %h, actual %h", idx, key_shadow[idx], prdata);
            errors++;
        end
    endtask

    task automatic load_keys(input logic [31:0] words [XT3_KEY_WRDS]);
        for (int i = 0; i < XT3_KEY_WRDS; i++) reg_write(i, words[i]);
        for (int i = 0; i < XT3_KEY_WRDS; i++) reg_read_check(i);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_pipe();
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic offer_block(input logic kind, input logic [127:0] blk);
        while (!calm && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= blk;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_blocks.push_back(xtea3_transform(kind, blk));
    endtask

    // receiver: random stalls, a calm stretch, and one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_blocks.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                logic [127:0] want;
                want = pending_blocks.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                        $error("out_word%0d: expected %h, actual %h",
                               i, want[32*i +: 32], m_tdata[32*i +: 32]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] keys [XT3_KEY_WRDS];
        for (int i = 0; i < XT3_KEY_WRDS; i++) key_shadow[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // key words read back as zero after reset
        for (int i = 0; i < XT3_KEY_WRDS; i++) reg_read_check(i);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        foreach (corner_blocks[k]) offer_block(corner_blocks[k][128], corner_blocks[k][127:0]);
        s_tvalid <= 1'b0;
        drain_pipe();

        for (int i = 0; i < XT3_KEY_WRDS; i++) keys[i] = 32'hFFFF_FFFF;
        load_keys(keys);
        foreach (corner_blocks[k]) offer_block(corner_blocks[k][128], corner_blocks[k][127:0]);
        s_tvalid <= 1'b0;
        drain_pipe();

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int i = 0; i < XT3_KEY_WRDS; i++) keys[i] = (p == 0) ? $urandom : pick_word();
            load_keys(keys);
            calm <= (p == 1);
            // stall the result side long enough to back the chain up into the input
            if (p == 2) hold_req <= hold_req + 1;
            for (int n = 0; n < RAND_PER_PASS; n++) begin
                offer_block(1'($urandom_range(1)),
                            {pick_word(), pick_word(), pick_word(), pick_word()});
            end
            s_tvalid <= 1'b0;
            drain_pipe();
            calm <= 1'b0;
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
src/xt3_pkg.sv
src/xt3_whiten_cell.sv
src/xt3_round_cell.sv
src/xtea3_block_cipher.sv
test/xtea3_block_cipher_tb.sv
